// ===== hw/rtl/dpcs_pkg.sv =====
// Shared types, constants and waveform table of the dot panel column sequencer.
`timescale 1ns / 1ps
`default_nettype none
package dpcs_pkg;

    localparam int unsigned DATA_W       = 16;
    localparam int unsigned BOARD_W      = 3;
    localparam int unsigned COL_W        = 7;
    localparam int unsigned COUNT_W      = 3;
    localparam int unsigned WAIT_W       = 15;
    localparam int unsigned NUM_COL_REGS = 5;
    localparam int unsigned BOARD_SLOTS  = 8;
    localparam int unsigned NB_W         = 4;
    localparam int unsigned DEFAULT_COLS = 16;
    localparam int unsigned CMD_DEPTH    = 2;
    localparam int unsigned STEP_W       = 5;
    localparam int unsigned INIT_STEPS   = 11;
    localparam int unsigned DRIVE_STEPS  = 9;
    localparam int unsigned LAST_STEP    = INIT_STEPS + DRIVE_STEPS - 1;
    localparam int unsigned APB_ADDR_W   = 5;
    localparam int unsigned APB_DATA_W   = 32;

    typedef enum logic [2:0] {
        REG_BOARD_COUNT = 3'd0,
        REG_COLUMNS_0   = 3'd1,
        REG_COLUMNS_1   = 3'd2,
        REG_COLUMNS_2   = 3'd3,
        REG_COLUMNS_3   = 3'd4,
        REG_COLUMNS_4   = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        DRV_ZERO = 2'd0,
        DRV_ONES = 2'd1,
        DRV_DATA = 2'd2
    } t_drv;

    typedef struct packed {
        logic [COUNT_W-1:0]                  board_count;
        logic [NUM_COL_REGS-1:0][COL_W-1:0]  columns;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [BOARD_W-1:0] board;
        logic               with_init;
    } t_cmd;

    typedef struct packed {
        logic              clr;
        logic              clk;
        logic              rst;
        logic              sel;
        t_drv              drv;
        logic [WAIT_W-1:0] wait_us;
    } t_step;

    function automatic t_step mk(input logic clr, input logic clk, input logic rst,
                                 input logic sel, input t_drv drv,
                                 input logic [WAIT_W-1:0] wait_us);
        t_step s;
        s.clr     = clr;
        s.clk     = clk;
        s.rst     = rst;
        s.sel     = sel;
        s.drv     = drv;
        s.wait_us = wait_us;
        return s;
    endfunction

    // Steps A to K of the initialization, then L to T of the column drive.
    function automatic t_step wave_step(input logic [STEP_W-1:0] idx);
        t_step s;
        unique case (idx)
            5'd0:    s = mk(1'b0, 1'b1, 1'b0, 1'b1, DRV_ZERO, 15'd0);
            5'd1:    s = mk(1'b1, 1'b1, 1'b0, 1'b1, DRV_ZERO, 15'd30000);
            5'd2:    s = mk(1'b1, 1'b1, 1'b0, 1'b1, DRV_ONES, 15'd0);
            5'd3:    s = mk(1'b1, 1'b1, 1'b0, 1'b1, DRV_ZERO, 15'd200);
            5'd4:    s = mk(1'b0, 1'b1, 1'b0, 1'b1, DRV_ZERO, 15'd0);
            5'd5:    s = mk(1'b0, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd100);
            5'd6:    s = mk(1'b0, 1'b1, 1'b1, 1'b0, DRV_ZERO, 15'd0);
            5'd7:    s = mk(1'b1, 1'b0, 1'b1, 1'b0, DRV_ZERO, 15'd200);
            5'd8:    s = mk(1'b1, 1'b1, 1'b1, 1'b0, DRV_ZERO, 15'd20);
            5'd9:    s = mk(1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd0);
            5'd10:   s = mk(1'b0, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd30);
            5'd11:   s = mk(1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd2000);
            5'd12:   s = mk(1'b1, 1'b0, 1'b1, 1'b1, DRV_ZERO, 15'd200);
            5'd13:   s = mk(1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd20);
            5'd14:   s = mk(1'b1, 1'b1, 1'b1, 1'b1, DRV_DATA, 15'd0);
            5'd15:   s = mk(1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd2000);
            5'd16:   s = mk(1'b0, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd0);
            5'd17:   s = mk(1'b1, 1'b0, 1'b1, 1'b1, DRV_ZERO, 15'd200);
            5'd18:   s = mk(1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd10);
            5'd19:   s = mk(1'b0, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd40);
            default: s = mk(1'b0, 1'b0, 1'b0, 1'b0, DRV_ZERO, 15'd0);
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dpcs_col_if.sv =====
// Column input channel: valid, ready and one column of dot bits.
`timescale 1ns / 1ps
`default_nettype none
interface dpcs_col_if;
    logic        valid;
    logic        ready;
    logic [15:0] column_bits;

    modport source (output valid, output column_bits, input ready);
    modport sink   (input valid, input column_bits, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dpcs_step_if.sv =====
// Step output channel: valid, ready and one latched panel step.
`timescale 1ns / 1ps
`default_nettype none
interface dpcs_step_if;
    logic        valid;
    logic        ready;
    logic        clear_line;
    logic        clock_line;
    logic        reset_line;
    logic        select_active;
    logic [2:0]  board;
    logic [15:0] column_drive;
    logic        output_enable;
    logic [14:0] wait_us;
    logic        last;

    modport source (output valid, output clear_line, output clock_line, output reset_line,
                    output select_active, output board, output column_drive,
                    output output_enable, output wait_us, output last, input ready);
    modport sink   (input valid, input clear_line, input clock_line, input reset_line,
                    input select_active, input board, input column_drive,
                    input output_enable, input wait_us, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dpcs_front.sv =====
// Front end: accepts columns, tracks board and column position, issues commands.
`timescale 1ns / 1ps
`default_nettype none
module dpcs_front #(
    parameter int unsigned MAX_BOARDS = 5
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  dpcs_pkg::t_cfg   i_cfg,
    dpcs_col_if.sink         i_col,
    input  wire              i_cmd_full,
    output logic             o_cmd_push,
    output dpcs_pkg::t_cmd   o_cmd
);

    localparam logic [dpcs_pkg::NB_W-1:0] MaxNb =
        (MAX_BOARDS > dpcs_pkg::BOARD_SLOTS) ? dpcs_pkg::NB_W'(dpcs_pkg::BOARD_SLOTS)
                                             : dpcs_pkg::NB_W'(MAX_BOARDS);

    logic [dpcs_pkg::BOARD_W-1:0] r_board, n_board;
    logic [dpcs_pkg::COL_W-1:0]   r_col, n_col;
    logic [dpcs_pkg::NB_W-1:0]    nb;
    logic [dpcs_pkg::BOARD_W-1:0] b;
    logic [dpcs_pkg::COL_W-1:0]   c;
    logic [dpcs_pkg::COL_W-1:0]   cols;
    logic [dpcs_pkg::NB_W-1:0]    b_inc;
    logic                         accept;

    assign i_col.ready = !i_cmd_full;
    assign accept      = i_col.valid && !i_cmd_full;

    always_comb begin
        nb = {1'b0, i_cfg.board_count};
        if (nb == '0) begin
            nb = dpcs_pkg::NB_W'(1);
        end
        if (nb > MaxNb) begin
            nb = MaxNb;
        end
    end

    always_comb begin
        if ({1'b0, r_board} >= nb) begin
            b = '0;
            c = '0;
        end else begin
            b = r_board;
            c = r_col;
        end
    end

    always_comb begin
        case (b)
            3'd0:    cols = i_cfg.columns[0];
            3'd1:    cols = i_cfg.columns[1];
            3'd2:    cols = i_cfg.columns[2];
            3'd3:    cols = i_cfg.columns[3];
            3'd4:    cols = i_cfg.columns[4];
            default: cols = dpcs_pkg::COL_W'(dpcs_pkg::DEFAULT_COLS);
        endcase
    end

    always_comb begin
        b_inc = {1'b0, b} + dpcs_pkg::NB_W'(1);
        if (({1'b0, c} + 8'd1) >= {1'b0, cols}) begin
            n_col = '0;
            n_board = (b_inc >= nb) ? '0 : b_inc[dpcs_pkg::BOARD_W-1:0];
        end else begin
            n_col   = c + dpcs_pkg::COL_W'(1);
            n_board = b;
        end
    end

    assign o_cmd_push      = accept;
    assign o_cmd.data      = i_col.column_bits;
    assign o_cmd.board     = b;
    assign o_cmd.with_init = (c == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board <= '0;
            r_col   <= '0;
        end else if (accept) begin
            r_board <= n_board;
            r_col   <= n_col;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dpcs_cmd_fifo.sv =====
// Two-entry command queue between the front end and the step generator.
`timescale 1ns / 1ps
`default_nettype none
module dpcs_cmd_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  dpcs_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_valid,
    output dpcs_pkg::t_cmd  o_cmd
);

    localparam int unsigned PtrW = $clog2(dpcs_pkg::CMD_DEPTH);
    localparam int unsigned CntW = $clog2(dpcs_pkg::CMD_DEPTH + 1);

    dpcs_pkg::t_cmd    r_mem [dpcs_pkg::CMD_DEPTH];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [CntW-1:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CntW'(dpcs_pkg::CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(dpcs_pkg::CMD_DEPTH - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(dpcs_pkg::CMD_DEPTH - 1)) ? '0 : r_rd + PtrW'(1);
            end
            r_cnt <= r_cnt + CntW'(do_push) - CntW'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dpcs_back.sv =====
// Back end: walks the step table for each command and registers one step per beat.
`timescale 1ns / 1ps
`default_nettype none
module dpcs_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cmd_valid,
    input  dpcs_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    dpcs_step_if.source      o_step
);

    logic                          r_busy;
    dpcs_pkg::t_cmd                r_cmd;
    logic [dpcs_pkg::STEP_W-1:0]   r_step;
    logic                          r_enabled;
    logic                          r_valid;
    logic                          emit, last_emit;
    dpcs_pkg::t_step               cur;
    logic [dpcs_pkg::DATA_W-1:0]   drive;

    assign emit      = r_busy && (!r_valid || o_step.ready);
    assign last_emit = emit && (r_step == dpcs_pkg::STEP_W'(dpcs_pkg::LAST_STEP));
    assign o_cmd_pop = i_cmd_valid && (!r_busy || last_emit);
    assign cur       = dpcs_pkg::wave_step(r_step);

    always_comb begin
        unique case (cur.drv)
            dpcs_pkg::DRV_ONES: drive = '1;
            dpcs_pkg::DRV_DATA: drive = r_cmd.data;
            default:            drive = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_enabled <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_busy <= 1'b1;
            end else if (last_emit) begin
                r_busy <= 1'b0;
            end
            if (emit && r_step == '0) begin
                r_enabled <= 1'b1;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (o_step.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd  <= i_cmd;
            r_step <= i_cmd.with_init ? '0 : dpcs_pkg::STEP_W'(dpcs_pkg::INIT_STEPS);
        end else if (emit) begin
            r_step <= r_step + dpcs_pkg::STEP_W'(1);
        end
        if (emit) begin
            o_step.clear_line    <= cur.clr;
            o_step.clock_line    <= cur.clk;
            o_step.reset_line    <= cur.rst;
            o_step.select_active <= cur.sel;
            o_step.board         <= r_cmd.board;
            o_step.column_drive  <= drive;
            o_step.output_enable <= r_enabled;
            o_step.wait_us       <= cur.wait_us;
            o_step.last          <= (r_step == dpcs_pkg::STEP_W'(dpcs_pkg::LAST_STEP));
        end
    end

    assign o_step.valid = r_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/dot_panel_column_sequencer.sv =====
// Top level of the dot panel column sequencer: register file and front/back hookup.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted column produces 20 output beats when it is the first column of a
// board (11 initialization steps A-K, then 9 drive steps L-T) and 9 beats otherwise,
// the last one marked. The step generator issues one beat per cycle from its step
// counter while the output is not stalled; columns are taken back to back while
// the two-entry command queue has room. Board and column position advance as
// columns are accepted. Registers must be written over APB only while the block is
// idle; the block itself does not enforce this. There is no clearing pass after reset.
module dot_panel_column_sequencer #(
    parameter int unsigned MAX_BOARDS = 5
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [dpcs_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [dpcs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dpcs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    dpcs_col_if.sink                            i_col,
    dpcs_step_if.source                         o_step
);

    dpcs_pkg::t_cfg     r_cfg;
    dpcs_pkg::t_reg_idx reg_idx;
    dpcs_pkg::t_cmd     push_cmd, head_cmd;
    logic               cmd_push, cmd_full, cmd_valid, cmd_pop;

    assign pready  = 1'b1;
    assign reg_idx = dpcs_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.board_count <= dpcs_pkg::COUNT_W'(1);
            for (int i = 0; i < dpcs_pkg::NUM_COL_REGS; i++) begin
                r_cfg.columns[i] <= dpcs_pkg::COL_W'(dpcs_pkg::DEFAULT_COLS);
            end
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                dpcs_pkg::REG_BOARD_COUNT: r_cfg.board_count <= pwdata[dpcs_pkg::COUNT_W-1:0];
                dpcs_pkg::REG_COLUMNS_0:   r_cfg.columns[0]  <= pwdata[dpcs_pkg::COL_W-1:0];
                dpcs_pkg::REG_COLUMNS_1:   r_cfg.columns[1]  <= pwdata[dpcs_pkg::COL_W-1:0];
                dpcs_pkg::REG_COLUMNS_2:   r_cfg.columns[2]  <= pwdata[dpcs_pkg::COL_W-1:0];
                dpcs_pkg::REG_COLUMNS_3:   r_cfg.columns[3]  <= pwdata[dpcs_pkg::COL_W-1:0];
                dpcs_pkg::REG_COLUMNS_4:   r_cfg.columns[4]  <= pwdata[dpcs_pkg::COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dpcs_pkg::REG_BOARD_COUNT:
                prdata = dpcs_pkg::APB_DATA_W'(r_cfg.board_count);
            dpcs_pkg::REG_COLUMNS_0: prdata = dpcs_pkg::APB_DATA_W'(r_cfg.columns[0]);
            dpcs_pkg::REG_COLUMNS_1: prdata = dpcs_pkg::APB_DATA_W'(r_cfg.columns[1]);
            dpcs_pkg::REG_COLUMNS_2: prdata = dpcs_pkg::APB_DATA_W'(r_cfg.columns[2]);
            dpcs_pkg::REG_COLUMNS_3: prdata = dpcs_pkg::APB_DATA_W'(r_cfg.columns[3]);
            dpcs_pkg::REG_COLUMNS_4: prdata = dpcs_pkg::APB_DATA_W'(r_cfg.columns[4]);
            default:                 prdata = '0;
        endcase
    end

    dpcs_front #(
        .MAX_BOARDS (MAX_BOARDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_col      (i_col),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (push_cmd)
    );

    dpcs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (push_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    dpcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_step      (o_step)
    );

endmodule
`default_nettype wire

// ===== tb/sv/dpcs_step_check.sv =====
// Step checker: mirrors the panel registers, predicts every step beat of each column and compares.
`timescale 1ns / 1ps
module dpcs_step_check import dpcs_pkg::*; #(
    parameter int unsigned MAX_BOARDS = 5
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    input  wire                   pready,
    dpcs_col_if                   i_col,
    dpcs_step_if                  i_step,
    output int unsigned           o_mismatches,
    output logic                  o_idle
);

    typedef struct packed {
        logic              clr;
        logic              clk;
        logic              rst;
        logic              sel;
        t_drv              drv;
        logic [WAIT_W-1:0] wait_us;
    } t_wave;

    typedef struct {
        logic               clear_line;
        logic               clock_line;
        logic               reset_line;
        logic               select_active;
        logic [BOARD_W-1:0] board;
        logic [DATA_W-1:0]  column_drive;
        logic               output_enable;
        logic [WAIT_W-1:0]  wait_us;
        logic               last;
    } t_panel_beat;

    logic [COUNT_W-1:0] cfg_boards;
    logic [COL_W-1:0]   cfg_cols [NUM_COL_REGS];
    logic [BOARD_W-1:0] cur_board;
    logic [COL_W-1:0]   cur_col;
    logic               oe_state;
    t_panel_beat        expected_beats [$];
    int unsigned        mismatch_total = 0;

    function automatic t_wave panel_wave(input int idx);
        case (idx)
            0:  return t_wave'{1'b0, 1'b1, 1'b0, 1'b1, DRV_ZERO, 15'd0};
            1:  return t_wave'{1'b1, 1'b1, 1'b0, 1'b1, DRV_ZERO, 15'd30000};
            2:  return t_wave'{1'b1, 1'b1, 1'b0, 1'b1, DRV_ONES, 15'd0};
            3:  return t_wave'{1'b1, 1'b1, 1'b0, 1'b1, DRV_ZERO, 15'd200};
            4:  return t_wave'{1'b0, 1'b1, 1'b0, 1'b1, DRV_ZERO, 15'd0};
            5:  return t_wave'{1'b0, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd100};
            6:  return t_wave'{1'b0, 1'b1, 1'b1, 1'b0, DRV_ZERO, 15'd0};
            7:  return t_wave'{1'b1, 1'b0, 1'b1, 1'b0, DRV_ZERO, 15'd200};
            8:  return t_wave'{1'b1, 1'b1, 1'b1, 1'b0, DRV_ZERO, 15'd20};
            9:  return t_wave'{1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd0};
            10: return t_wave'{1'b0, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd30};
            11: return t_wave'{1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd2000};
            12: return t_wave'{1'b1, 1'b0, 1'b1, 1'b1, DRV_ZERO, 15'd200};
            13: return t_wave'{1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd20};
            14: return t_wave'{1'b1, 1'b1, 1'b1, 1'b1, DRV_DATA, 15'd0};
            15: return t_wave'{1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd2000};
            16: return t_wave'{1'b0, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd0};
            17: return t_wave'{1'b1, 1'b0, 1'b1, 1'b1, DRV_ZERO, 15'd200};
            18: return t_wave'{1'b1, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd10};
            default: return t_wave'{1'b0, 1'b1, 1'b1, 1'b1, DRV_ZERO, 15'd40};
        endcase
    endfunction

    task automatic plan_column_steps(input logic [DATA_W-1:0] bits);
        int unsigned live;
        int          first;
        int          col_limit;
        t_wave       w;
        t_panel_beat b;
        live = (cfg_boards == 0) ? 1 : ((cfg_boards > MAX_BOARDS) ? MAX_BOARDS : cfg_boards);
        if (cur_board >= live) begin
            cur_board = '0;
            cur_col   = '0;
        end
        first = (cur_col == 0) ? 0 : INIT_STEPS;
        for (int i = first; i < INIT_STEPS + DRIVE_STEPS; i++) begin
            w = panel_wave(i);
            b.clear_line    = w.clr;
            b.clock_line    = w.clk;
            b.reset_line    = w.rst;
            b.select_active = w.sel;
            b.board         = cur_board;
            b.column_drive  = (w.drv == DRV_ONES) ? 16'hFFFF :
                              (w.drv == DRV_DATA) ? bits : 16'h0000;
            b.output_enable = oe_state;
            b.wait_us       = w.wait_us;
            b.last          = (i == LAST_STEP);
            expected_beats.push_back(b);
            if (i == 0) oe_state = 1'b1;
        end
        col_limit = (cur_board < NUM_COL_REGS) ? int'(cfg_cols[cur_board]) : DEFAULT_COLS;
        if (int'(cur_col) + 1 >= col_limit) begin
            cur_col   = '0;
            cur_board = (int'(cur_board) + 1 >= live) ? '0 : cur_board + 1'b1;
        end else begin
            cur_col = cur_col + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_total++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_panel_beat want;
        logic [2:0]  reg_sel;
        if (!i_rst_n) begin
            cfg_boards = 3'd1;
            foreach (cfg_cols[i]) cfg_cols[i] = COL_W'(DEFAULT_COLS);
            cur_board = '0;
            cur_col   = '0;
            oe_state  = 1'b0;
            expected_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_sel = paddr[APB_ADDR_W-1:2];
                if (reg_sel == REG_BOARD_COUNT)
                    cfg_boards = pwdata[COUNT_W-1:0];
                else if (reg_sel <= REG_COLUMNS_4)
                    cfg_cols[reg_sel - REG_COLUMNS_0] = pwdata[COL_W-1:0];
            end
            if (i_col.valid && i_col.ready) plan_column_steps(i_col.column_bits);
            if (i_step.valid && i_step.ready) begin
                if (expected_beats.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: step beat expected none, got board %0h drive %0h last %0b",
                             $time, i_step.board, i_step.column_drive, i_step.last);
                end else begin
                    want = expected_beats.pop_front();
                    check_field("clear_line", 32'(want.clear_line), 32'(i_step.clear_line));
                    check_field("clock_line", 32'(want.clock_line), 32'(i_step.clock_line));
                    check_field("reset_line", 32'(want.reset_line), 32'(i_step.reset_line));
                    check_field("select_active", 32'(want.select_active),
                                32'(i_step.select_active));
                    check_field("board", 32'(want.board), 32'(i_step.board));
                    check_field("column_drive", 32'(want.column_drive),
                                32'(i_step.column_drive));
                    check_field("output_enable", 32'(want.output_enable),
                                32'(i_step.output_enable));
                    check_field("wait_us", 32'(want.wait_us), 32'(i_step.wait_us));
                    check_field("last", 32'(want.last), 32'(i_step.last));
                end
            end
        end
        o_idle       <= (expected_beats.size() == 0);
        o_mismatches <= mismatch_total;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: drives columns and register writes into the column sequencer and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import dpcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned PHASE_ITEMS   = 45;
    localparam logic [2:0]  REG_SPARE_6   = 3'd6;
    localparam logic [2:0]  REG_SPARE_7   = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int unsigned           mismatches;
    logic                  idle;
    int unsigned           cycles = 0;
    int                    tx_idle_pct = 0;
    int                    rx_stall_pct = 0;

    dpcs_col_if  col_ch ();
    dpcs_step_if step_ch ();

    dot_panel_column_sequencer #(.MAX_BOARDS(5)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_col   (col_ch),
        .o_step  (step_ch)
    );

    dpcs_step_check #(.MAX_BOARDS(5)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_col        (col_ch),
        .i_step       (step_ch),
        .o_mismatches (mismatches),
        .o_idle       (idle)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        step_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_column_bits();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [COL_W-1:0] pick_column_count();
        case ($urandom_range(15))
            0:       return 7'd0;
            1:       return 7'd127;
            2, 3:    return COL_W'($urandom_range(1, 127));
            default: return COL_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [COL_W-1:0] value);
        logic [APB_DATA_W-1:0] field_mask;
        field_mask = (idx == REG_BOARD_COUNT) ? 32'h7 : 32'h7F;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~field_mask) | (APB_DATA_W'(value) & field_mask);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_column(input logic [DATA_W-1:0] bits);
        if ($urandom_range(99) < tx_idle_pct) begin
            col_ch.valid       <= 1'b0;
            col_ch.column_bits <= DATA_W'($urandom());
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        col_ch.valid       <= 1'b1;
        col_ch.column_bits <= bits;
        @(posedge i_clk);
        while (!col_ch.ready) @(posedge i_clk);
    endtask

    // Hold the sender off until every predicted beat has come out.
    task automatic drain_steps();
        col_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (!idle) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [DATA_W-1:0] corner_bits [6];
        logic [COL_W-1:0]  mid_cols [NUM_COL_REGS];
        logic [COL_W-1:0]  cols;
        logic [2:0]        boards;
        corner_bits = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h8001, 16'h7FFE};
        mid_cols    = '{7'd1, 7'd2, 7'd1, 7'd3, 7'd1};
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        col_ch.valid       = 1'b0;
        col_ch.column_bits = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_bits[i]) send_column(corner_bits[i]);
        drain_steps();

        // shrink board 0 below the current column
        reg_write(REG_COLUMNS_0, 7'd3);
        send_column(16'h0F0F);
        send_column(16'hF0F0);
        drain_steps();

        reg_write(REG_BOARD_COUNT, 7'd0);
        reg_write(REG_COLUMNS_0, 7'd0);
        send_column(16'h1234);
        send_column(16'hEDCB);
        drain_steps();

        reg_write(REG_BOARD_COUNT, 7'd5);
        foreach (mid_cols[i]) reg_write(3'(REG_COLUMNS_0 + i), mid_cols[i]);
        repeat (5) send_column(pick_column_bits());
        drain_steps();

        // drop the board count below the current board
        reg_write(REG_BOARD_COUNT, 7'd2);
        repeat (3) send_column(pick_column_bits());
        drain_steps();

        reg_write(REG_BOARD_COUNT, 7'd7);
        reg_write(REG_SPARE_6, 7'd0);
        reg_write(REG_SPARE_7, 7'd127);
        repeat (3) send_column(pick_column_bits());

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    tx_idle_pct   = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct   = 59;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct   = 0;
                    rx_stall_pct <= 59;
                end
                default: begin
                    tx_idle_pct   = 24;
                    rx_stall_pct <= 24;
                end
            endcase
            drain_steps();
            boards = (ph == 2 || ph == 5) ? 3'd5 : 3'($urandom_range(0, 7));
            reg_write(REG_BOARD_COUNT, COL_W'(boards));
            for (int r = 0; r < NUM_COL_REGS; r++) begin
                cols = (ph == 2) ? 7'd127 : (ph == 5) ? 7'd1 : pick_column_count();
                reg_write(3'(REG_COLUMNS_0 + r), cols);
            end
            if ($urandom_range(3) == 0) reg_write(3'($urandom_range(6, 7)), COL_W'($urandom()));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(39) == 0) drain_steps();
                send_column(pick_column_bits());
            end
        end

        drain_steps();
        if (mismatches == 0 && idle === 1'b1) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
